@@ rtl/camera_view_matrix_orthonormalize_defines.svh @@
// Assertion macros shared by the camera view matrix checker.
// Depends on nothing; the including module supplies aclk and aresetn.
`ifndef CAMERA_VIEW_MATRIX_ORTHONORMALIZE_DEFINES_SVH
`define CAMERA_VIEW_MATRIX_ORTHONORMALIZE_DEFINES_SVH

// Same-cycle implication, off while in reset
`define CVMO_ASSERT_NOW(lbl, pre, post, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, off while in reset
`define CVMO_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error(msg);

// Next-cycle implication that also covers reset
`define CVMO_ASSERT_NEXT_RST(lbl, pre, post, msg) \
    lbl: assert property (@(posedge aclk) (pre) |=> (post)) \
        else $error(msg);

`endif

@@ rtl/cvmo_pkg.sv @@
// Shared constants for the camera view matrix orthonormalizer.
// No dependencies; used by cvmo_norm and the top level.
package cvmo_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int IN_W          = 32;   // input component width
    localparam int AXIS_W        = 18;   // axis output field width
    localparam int VEC_W         = 64;   // width of a vector fed to a normalizer
    localparam int MAG_W         = 63;   // magnitude width of such a vector
    localparam int MSB_W         = 6;    // bit index into a magnitude
    localparam int NM_W          = 31;   // normalized magnitude, MSB at bit 30
    localparam int NORM_TOP      = 30;   // target MSB position
    localparam int SQ_W          = 64;   // sum of squares
    localparam int LEN_W         = 32;   // integer square root
    localparam int NORM_BASE_LAT = 40;   // normalizer pipeline stages minus FRAC_BITS

    localparam logic signed [31:0] AXIS_MAX  = 32'sd131071;
    localparam logic signed [31:0] AXIS_MIN  = -32'sd131072;
    localparam logic signed [31:0] SHIFT_MAX = 32'sh7fffffff;
    localparam logic signed [31:0] SHIFT_MIN = 32'sh80000000;

endpackage

@@ rtl/camera_view_matrix_orthonormalize.sv @@
// Camera view matrix orthonormalizer top level: look-at basis rebuild.
// Depends on cvmo_pkg and cvmo_norm.
//
// Takes one camera transaction (position, look, up in signed Q.FRAC_BITS) per
// clock and returns unit look, right = norm(up x look), new up =
// norm(look x right), and the three saturated translations -(pos . axis).
// The datapath runs through three normalizer pipelines in series, each with a
// 32-stage square root and a FRAC_BITS+1 stage divide. Throughput is one
// transaction per cycle while the output is not blocked. The pipeline stalls
// as a whole only while a result waits at the output and m_ready is low; the
// input register still takes one more transaction then.
module camera_view_matrix_orthonormalize #(
    parameter int FRAC_BITS = cvmo_pkg::FRAC_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [cvmo_pkg::IN_W-1:0]    s_pos_x,
    input  logic signed [cvmo_pkg::IN_W-1:0]    s_pos_y,
    input  logic signed [cvmo_pkg::IN_W-1:0]    s_pos_z,
    input  logic signed [cvmo_pkg::IN_W-1:0]    s_look_x,
    input  logic signed [cvmo_pkg::IN_W-1:0]    s_look_y,
    input  logic signed [cvmo_pkg::IN_W-1:0]    s_look_z,
    input  logic signed [cvmo_pkg::IN_W-1:0]    s_up_x,
    input  logic signed [cvmo_pkg::IN_W-1:0]    s_up_y,
    input  logic signed [cvmo_pkg::IN_W-1:0]    s_up_z,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [cvmo_pkg::AXIS_W-1:0]  m_right_x,
    output logic signed [cvmo_pkg::AXIS_W-1:0]  m_right_y,
    output logic signed [cvmo_pkg::AXIS_W-1:0]  m_right_z,
    output logic signed [cvmo_pkg::AXIS_W-1:0]  m_new_up_x,
    output logic signed [cvmo_pkg::AXIS_W-1:0]  m_new_up_y,
    output logic signed [cvmo_pkg::AXIS_W-1:0]  m_new_up_z,
    output logic signed [cvmo_pkg::AXIS_W-1:0]  m_unit_look_x,
    output logic signed [cvmo_pkg::AXIS_W-1:0]  m_unit_look_y,
    output logic signed [cvmo_pkg::AXIS_W-1:0]  m_unit_look_z,
    output logic signed [cvmo_pkg::IN_W-1:0]    m_shift_x,
    output logic signed [cvmo_pkg::IN_W-1:0]    m_shift_y,
    output logic signed [cvmo_pkg::IN_W-1:0]    m_shift_z
);
    import cvmo_pkg::*;

    localparam int AX_W = FRAC_BITS + 2;
    localparam int NL   = NORM_BASE_LAT + FRAC_BITS;
    localparam int VL   = 3*NL + 7;          // stages after the input register
    localparam int PW1  = IN_W + AX_W;       // up x look products
    localparam int PW2  = 2*AX_W;            // look x right products
    localparam int DPW  = IN_W + AX_W;       // pos . axis products
    localparam int TW   = DPW + 3;           // translation before rounding
    localparam int V3W  = 3*IN_W;
    localparam int A3W  = 3*AX_W;
    localparam int POS_D   = 3*NL + 4;
    localparam int UP_D    = NL;
    localparam int LOOK_D  = 2*NL + 4;
    localparam int RIGHT_D = NL + 2;

    // global advance; stalls only while the output holds and is not taken
    logic en, in_ld;
    logic in_v_reg;
    logic v_reg [VL];

    assign en      = ~v_reg[VL-1] | m_ready;
    assign in_ld   = en | ~in_v_reg;
    assign s_ready = in_ld;
    assign m_valid = v_reg[VL-1];

    // input register
    logic signed [IN_W-1:0] pos_reg [3];
    logic signed [IN_W-1:0] look_reg [3];
    logic signed [IN_W-1:0] up_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_v_reg <= 1'b0;
        end else if (in_ld) begin
            in_v_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ld) begin
            pos_reg  <= '{s_pos_x, s_pos_y, s_pos_z};
            look_reg <= '{s_look_x, s_look_y, s_look_z};
            up_reg   <= '{s_up_x, s_up_y, s_up_z};
        end
    end

    // valid bits travel with the data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < VL; k++) begin
                v_reg[k] <= 1'b0;
            end
        end else if (en) begin
            v_reg[0] <= in_v_reg;
            for (int k = 1; k < VL; k++) begin
                v_reg[k] <= v_reg[k-1];
            end
        end
    end

    // normalize look
    logic signed [AX_W-1:0] ula [3];

    cvmo_norm #(.FRAC_BITS(FRAC_BITS)) u_norm_look (
        .aclk (aclk),
        .en   (en),
        .c_x  (VEC_W'(look_reg[0])),
        .c_y  (VEC_W'(look_reg[1])),
        .c_z  (VEC_W'(look_reg[2])),
        .n_x  (ula[0]),
        .n_y  (ula[1]),
        .n_z  (ula[2])
    );

    // delay lines for side data
    logic [V3W-1:0] pos_dl_reg   [POS_D];
    logic [V3W-1:0] up_dl_reg    [UP_D];
    logic [A3W-1:0] look_dl_reg  [LOOK_D];
    logic [A3W-1:0] right_dl_reg [RIGHT_D];
    logic signed [AX_W-1:0] urt [3];

    always_ff @(posedge aclk) begin
        if (en) begin
            pos_dl_reg[0]   <= {pos_reg[2], pos_reg[1], pos_reg[0]};
            up_dl_reg[0]    <= {up_reg[2], up_reg[1], up_reg[0]};
            look_dl_reg[0]  <= {ula[2], ula[1], ula[0]};
            right_dl_reg[0] <= {urt[2], urt[1], urt[0]};
            for (int k = 1; k < POS_D; k++) begin
                pos_dl_reg[k] <= pos_dl_reg[k-1];
            end
            for (int k = 1; k < UP_D; k++) begin
                up_dl_reg[k] <= up_dl_reg[k-1];
            end
            for (int k = 1; k < LOOK_D; k++) begin
                look_dl_reg[k] <= look_dl_reg[k-1];
            end
            for (int k = 1; k < RIGHT_D; k++) begin
                right_dl_reg[k] <= right_dl_reg[k-1];
            end
        end
    end

    // taps
    logic signed [IN_W-1:0] up_d   [3];
    logic signed [IN_W-1:0] pos_d  [3];
    logic signed [AX_W-1:0] ul_c2  [3];
    logic signed [AX_W-1:0] ul_dot [3];
    logic signed [AX_W-1:0] rt_dot [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            up_d[i]   = $signed(up_dl_reg[UP_D-1][i*IN_W +: IN_W]);
            pos_d[i]  = $signed(pos_dl_reg[POS_D-1][i*IN_W +: IN_W]);
            ul_c2[i]  = $signed(look_dl_reg[RIGHT_D-1][i*AX_W +: AX_W]);
            ul_dot[i] = $signed(look_dl_reg[LOOK_D-1][i*AX_W +: AX_W]);
            rt_dot[i] = $signed(right_dl_reg[RIGHT_D-1][i*AX_W +: AX_W]);
        end
    end

    // cross product up x look: products, then differences
    logic signed [PW1-1:0]   p1_reg [6];
    logic signed [VEC_W-1:0] x1_reg [3];

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_reg[0] <= PW1'(up_d[1]) * PW1'(ula[2]);
            p1_reg[1] <= PW1'(up_d[2]) * PW1'(ula[1]);
            p1_reg[2] <= PW1'(up_d[2]) * PW1'(ula[0]);
            p1_reg[3] <= PW1'(up_d[0]) * PW1'(ula[2]);
            p1_reg[4] <= PW1'(up_d[0]) * PW1'(ula[1]);
            p1_reg[5] <= PW1'(up_d[1]) * PW1'(ula[0]);
            for (int i = 0; i < 3; i++) begin
                x1_reg[i] <= VEC_W'(p1_reg[2*i]) - VEC_W'(p1_reg[2*i+1]);
            end
        end
    end

    cvmo_norm #(.FRAC_BITS(FRAC_BITS)) u_norm_right (
        .aclk (aclk),
        .en   (en),
        .c_x  (x1_reg[0]),
        .c_y  (x1_reg[1]),
        .c_z  (x1_reg[2]),
        .n_x  (urt[0]),
        .n_y  (urt[1]),
        .n_z  (urt[2])
    );

    // cross product look x right
    logic signed [PW2-1:0]   p2_reg [6];
    logic signed [VEC_W-1:0] x2_reg [3];

    always_ff @(posedge aclk) begin
        if (en) begin
            p2_reg[0] <= PW2'(ul_c2[1]) * PW2'(urt[2]);
            p2_reg[1] <= PW2'(ul_c2[2]) * PW2'(urt[1]);
            p2_reg[2] <= PW2'(ul_c2[2]) * PW2'(urt[0]);
            p2_reg[3] <= PW2'(ul_c2[0]) * PW2'(urt[2]);
            p2_reg[4] <= PW2'(ul_c2[0]) * PW2'(urt[1]);
            p2_reg[5] <= PW2'(ul_c2[1]) * PW2'(urt[0]);
            for (int i = 0; i < 3; i++) begin
                x2_reg[i] <= VEC_W'(p2_reg[2*i]) - VEC_W'(p2_reg[2*i+1]);
            end
        end
    end

    logic signed [AX_W-1:0] unu [3];

    cvmo_norm #(.FRAC_BITS(FRAC_BITS)) u_norm_up (
        .aclk (aclk),
        .en   (en),
        .c_x  (x2_reg[0]),
        .c_y  (x2_reg[1]),
        .c_z  (x2_reg[2]),
        .n_x  (unu[0]),
        .n_y  (unu[1]),
        .n_z  (unu[2])
    );

    // translations: products (axis order right, up, look), then rounded sums
    logic signed [AX_W-1:0] ax1_reg [9];
    logic signed [AX_W-1:0] ax2_reg [9];
    logic signed [DPW-1:0]  d1_reg  [9];
    logic signed [TW-1:0]   t2_reg  [3];

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                ax1_reg[i]   <= rt_dot[i];
                ax1_reg[3+i] <= unu[i];
                ax1_reg[6+i] <= ul_dot[i];
            end
            for (int a = 0; a < 3; a++) begin
                for (int i = 0; i < 3; i++) begin
                    d1_reg[3*a+i] <= DPW'(pos_d[i]) * DPW'(ax1_next_sel(a, i));
                end
            end
            ax2_reg <= ax1_reg;
            for (int a = 0; a < 3; a++) begin
                t2_reg[a] <= -(TW'(d1_reg[3*a]) + TW'(d1_reg[3*a+1]) + TW'(d1_reg[3*a+2]))
                             + (TW'(1) << (FRAC_BITS - 1));
            end
        end
    end

    function automatic logic signed [AX_W-1:0] ax1_next_sel(input int a, input int i);
        logic signed [AX_W-1:0] r;
        case (a)
            0:       r = rt_dot[i];
            1:       r = unu[i];
            default: r = ul_dot[i];
        endcase
        return r;
    endfunction

    // output register: round by arithmetic shift, saturate
    logic signed [AXIS_W-1:0] ax_o_reg [9];
    logic signed [IN_W-1:0]   sh_o_reg [3];
    logic signed [AXIS_W-1:0] ax_o_next [9];
    logic signed [IN_W-1:0]   sh_o_next [3];
    logic signed [TW-1:0]     rnd [3];
    logic signed [31:0]       axe [9];

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            axe[k] = 32'(ax2_reg[k]);
            if (axe[k] > AXIS_MAX) begin
                ax_o_next[k] = AXIS_W'(AXIS_MAX);
            end else if (axe[k] < AXIS_MIN) begin
                ax_o_next[k] = AXIS_W'(AXIS_MIN);
            end else begin
                ax_o_next[k] = AXIS_W'(axe[k]);
            end
        end
        for (int a = 0; a < 3; a++) begin
            rnd[a] = t2_reg[a] >>> FRAC_BITS;
            if (rnd[a] > TW'(SHIFT_MAX)) begin
                sh_o_next[a] = SHIFT_MAX;
            end else if (rnd[a] < TW'(SHIFT_MIN)) begin
                sh_o_next[a] = SHIFT_MIN;
            end else begin
                sh_o_next[a] = IN_W'(rnd[a]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ax_o_reg <= ax_o_next;
            sh_o_reg <= sh_o_next;
        end
    end

    assign m_right_x     = ax_o_reg[0];
    assign m_right_y     = ax_o_reg[1];
    assign m_right_z     = ax_o_reg[2];
    assign m_new_up_x    = ax_o_reg[3];
    assign m_new_up_y    = ax_o_reg[4];
    assign m_new_up_z    = ax_o_reg[5];
    assign m_unit_look_x = ax_o_reg[6];
    assign m_unit_look_y = ax_o_reg[7];
    assign m_unit_look_z = ax_o_reg[8];
    assign m_shift_x     = sh_o_reg[0];
    assign m_shift_y     = sh_o_reg[1];
    assign m_shift_z     = sh_o_reg[2];

endmodule

@@ rtl/cvmo_norm.sv @@
// Pipelined 3-vector normalizer: block scaling, sum of squares, 32-step
// square root and FRAC_BITS+1 step divides. Depends on cvmo_pkg.
module cvmo_norm #(
    parameter int FRAC_BITS = cvmo_pkg::FRAC_BITS_DEF,
    localparam int AX_W = FRAC_BITS + 2
) (
    input  logic                             aclk,
    input  logic                             en,
    input  logic signed [cvmo_pkg::VEC_W-1:0] c_x,
    input  logic signed [cvmo_pkg::VEC_W-1:0] c_y,
    input  logic signed [cvmo_pkg::VEC_W-1:0] c_z,
    output logic signed [AX_W-1:0]           n_x,
    output logic signed [AX_W-1:0]           n_y,
    output logic signed [AX_W-1:0]           n_z
);
    import cvmo_pkg::*;

    localparam int ND   = LEN_W + FRAC_BITS;  // dividend width
    localparam int NDIV = FRAC_BITS + 1;      // quotient bits
    localparam int NSQ  = LEN_W;              // root bits

    logic signed [VEC_W-1:0] c_in [3];
    assign c_in[0] = c_x;
    assign c_in[1] = c_y;
    assign c_in[2] = c_z;

    // stage 1: magnitudes and signs
    logic [MAG_W-1:0] mag_reg [3];
    logic [MAG_W-1:0] mag_next [3];
    logic [2:0]       sgn1_reg, sgn1_next;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            sgn1_next[i] = c_in[i][VEC_W-1];
            mag_next[i]  = c_in[i][VEC_W-1] ? MAG_W'(-c_in[i]) : MAG_W'(c_in[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mag_reg  <= mag_next;
            sgn1_reg <= sgn1_next;
        end
    end

    // stage 2: leading one of the largest magnitude (same as of the OR)
    logic [MAG_W-1:0] mag2_reg [3];
    logic [2:0]       sgn2_reg;
    logic [MSB_W-1:0] msb2_reg, msb2_next;
    logic             zero2_reg, zero2_next;
    logic [MAG_W-1:0] or_all;

    always_comb begin
        or_all     = mag_reg[0] | mag_reg[1] | mag_reg[2];
        zero2_next = (or_all == '0);
        msb2_next  = '0;
        for (int j = 0; j < MAG_W; j++) begin
            if (or_all[j]) begin
                msb2_next = MSB_W'(j);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mag2_reg  <= mag_reg;
            sgn2_reg  <= sgn1_reg;
            msb2_reg  <= msb2_next;
            zero2_reg <= zero2_next;
        end
    end

    // stage 3: shift all three so the largest has its MSB at bit 30
    logic [NM_W-1:0] nm3_reg [3];
    logic [NM_W-1:0] nm3_next [3];
    logic [2:0]      sgn3_reg;
    logic            zero3_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (msb2_reg >= MSB_W'(NORM_TOP)) begin
                nm3_next[i] = NM_W'(mag2_reg[i] >> (msb2_reg - MSB_W'(NORM_TOP)));
            end else begin
                nm3_next[i] = NM_W'(mag2_reg[i] << (MSB_W'(NORM_TOP) - msb2_reg));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            nm3_reg   <= nm3_next;
            sgn3_reg  <= sgn2_reg;
            zero3_reg <= zero2_reg;
        end
    end

    // stage 4: squares
    logic [2*NM_W-1:0] sq4_reg [3];
    logic [NM_W-1:0]   nm4_reg [3];
    logic [2:0]        sgn4_reg;
    logic              zero4_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                sq4_reg[i] <= (2*NM_W)'(nm3_reg[i]) * (2*NM_W)'(nm3_reg[i]);
            end
            nm4_reg   <= nm3_reg;
            sgn4_reg  <= sgn3_reg;
            zero4_reg <= zero3_reg;
        end
    end

    // stage 5 (root pipe entry): sum of squares
    logic [SQ_W-1:0]     sx_reg  [NSQ+1];
    logic [SQ_W-1:0]     sr_reg  [NSQ+1];
    logic [3*NM_W-1:0]   snm_reg [NSQ+1];
    logic [2:0]          ssg_reg [NSQ+1];
    logic                sz_reg  [NSQ+1];

    always_ff @(posedge aclk) begin
        if (en) begin
            sx_reg[0]  <= SQ_W'(sq4_reg[0]) + SQ_W'(sq4_reg[1]) + SQ_W'(sq4_reg[2]);
            sr_reg[0]  <= '0;
            snm_reg[0] <= {nm4_reg[2], nm4_reg[1], nm4_reg[0]};
            ssg_reg[0] <= sgn4_reg;
            sz_reg[0]  <= zero4_reg;
        end
    end

    // square root, one result bit per stage
    for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
        localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (SQ_W - 2 - 2*k);
        logic [SQ_W:0]   trial;
        logic [SQ_W-1:0] x_next, r_next;

        always_comb begin
            trial = (SQ_W+1)'(sr_reg[k]) + (SQ_W+1)'(BIT);
            if ((SQ_W+1)'(sx_reg[k]) >= trial) begin
                x_next = sx_reg[k] - SQ_W'(trial);
                r_next = (sr_reg[k] >> 1) + BIT;
            end else begin
                x_next = sx_reg[k];
                r_next = sr_reg[k] >> 1;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                sx_reg[k+1]  <= x_next;
                sr_reg[k+1]  <= r_next;
                snm_reg[k+1] <= snm_reg[k];
                ssg_reg[k+1] <= ssg_reg[k];
                sz_reg[k+1]  <= sz_reg[k];
            end
        end
    end

    // divide pipe entry: rounded dividends
    logic [ND-1:0]     drem_reg [NDIV+1][3];
    logic [NDIV-1:0]   dq_reg   [NDIV+1][3];
    logic [LEN_W-1:0]  dl_reg   [NDIV+1];
    logic [2:0]        dsg_reg  [NDIV+1];
    logic              dz_reg   [NDIV+1];
    logic [LEN_W-1:0]  root_len;

    assign root_len = LEN_W'(sr_reg[NSQ]);

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                drem_reg[0][i] <= (ND'(snm_reg[NSQ][i*NM_W +: NM_W]) << FRAC_BITS)
                                  + ND'(root_len >> 1);
                dq_reg[0][i]   <= '0;
            end
            dl_reg[0]  <= root_len;
            dsg_reg[0] <= ssg_reg[NSQ];
            dz_reg[0]  <= sz_reg[NSQ];
        end
    end

    // restoring divide, one quotient bit per stage, MSB first
    for (genvar j = 0; j < NDIV; j++) begin : g_div
        localparam int QB = FRAC_BITS - j;
        logic [ND-1:0]   dvs;
        logic [ND-1:0]   rem_next [3];
        logic [NDIV-1:0] q_next   [3];

        always_comb begin
            dvs = ND'(dl_reg[j]) << QB;
            for (int i = 0; i < 3; i++) begin
                rem_next[i] = drem_reg[j][i];
                q_next[i]   = dq_reg[j][i];
                if (drem_reg[j][i] >= dvs) begin
                    rem_next[i]  = drem_reg[j][i] - dvs;
                    q_next[i][QB] = 1'b1;
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                for (int i = 0; i < 3; i++) begin
                    drem_reg[j+1][i] <= rem_next[i];
                    dq_reg[j+1][i]   <= q_next[i];
                end
                dl_reg[j+1]  <= dl_reg[j];
                dsg_reg[j+1] <= dsg_reg[j];
                dz_reg[j+1]  <= dz_reg[j];
            end
        end
    end

    // output: apply signs, zero vector gives zero
    logic signed [AX_W-1:0] n_reg  [3];
    logic signed [AX_W-1:0] n_next [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (dz_reg[NDIV]) begin
                n_next[i] = '0;
            end else if (dsg_reg[NDIV][i]) begin
                n_next[i] = -AX_W'(dq_reg[NDIV][i]);
            end else begin
                n_next[i] = AX_W'(dq_reg[NDIV][i]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            n_reg <= n_next;
        end
    end

    assign n_x = n_reg[0];
    assign n_y = n_reg[1];
    assign n_z = n_reg[2];

endmodule

@@ rtl/cvmo_checker.sv @@
// Port-level checks for the camera view matrix orthonormalizer, bound to the
// top level. Depends on camera_view_matrix_orthonormalize_defines.svh.
`include "camera_view_matrix_orthonormalize_defines.svh"

module cvmo_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_ready,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic signed [cvmo_pkg::AXIS_W-1:0]  m_right_x,
    input logic signed [cvmo_pkg::AXIS_W-1:0]  m_right_y,
    input logic signed [cvmo_pkg::AXIS_W-1:0]  m_right_z,
    input logic signed [cvmo_pkg::AXIS_W-1:0]  m_new_up_x,
    input logic signed [cvmo_pkg::AXIS_W-1:0]  m_new_up_y,
    input logic signed [cvmo_pkg::AXIS_W-1:0]  m_new_up_z,
    input logic signed [cvmo_pkg::AXIS_W-1:0]  m_unit_look_x,
    input logic signed [cvmo_pkg::AXIS_W-1:0]  m_unit_look_y,
    input logic signed [cvmo_pkg::AXIS_W-1:0]  m_unit_look_z
);
    logic right_zero, look_zero, up_zero;

    assign right_zero = (m_right_x == '0) && (m_right_y == '0) && (m_right_z == '0);
    assign up_zero    = (m_new_up_x == '0) && (m_new_up_y == '0) && (m_new_up_z == '0);
    assign look_zero  = (m_unit_look_x == '0) && (m_unit_look_y == '0)
                        && (m_unit_look_z == '0);

    // reset empties the output
    `CVMO_ASSERT_NEXT_RST(a_rst_empty, !aresetn, !m_valid, "output valid after reset")

    // a waiting transaction is held
    `CVMO_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid, "output dropped")

    // input back-pressure only while the output is blocked
    `CVMO_ASSERT_NOW(a_in_stall, !s_ready, m_valid && !m_ready, "input stalled needlessly")

    // zero look gives zero right; zero right gives zero up
    `CVMO_ASSERT_NOW(a_look_zero, m_valid && look_zero, right_zero, "right not zero")
    `CVMO_ASSERT_NOW(a_right_zero, m_valid && right_zero, up_zero, "new up not zero")

endmodule

bind camera_view_matrix_orthonormalize cvmo_checker u_cvmo_checker (.*);
